/* design/stack_machine_executor_core_macros.svh */
// ----------------------------------------------------------------------------
// Stack machine executor assertion macros
// Shared concurrent assertion forms for the checker of the executor core.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_CORE_MACROS_SVH
`define STACK_MACHINE_EXECUTOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held low.
`define SMX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stack machine executor check failed");

// Next-cycle implication, disabled while reset is held low.
`define SMX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack machine executor check failed");

`endif

/* design/smx_pkg.sv */
// ----------------------------------------------------------------------------
// Stack machine executor package
// Sizes, opcodes, status codes and inter-module structs of the executor.
// ----------------------------------------------------------------------------
`default_nettype none

package smx_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int IP_BITS     = 16;

    localparam int DATA_W      = 32;
    localparam int REQ_W       = 4;
    localparam int STATUS_W    = 3;
    localparam int NEXT_IP_W   = 16;
    localparam int DEPTH_OUT_W = 5;

    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    typedef enum logic [REQ_W-1:0] {
        OP_NONE  = 4'd0,
        OP_PUSH  = 4'd1,
        OP_LOAD  = 4'd2,
        OP_PRINT = 4'd3,
        OP_SCAN  = 4'd4,
        OP_ADD   = 4'd5,
        OP_SUB   = 4'd6,
        OP_MUL   = 4'd7,
        OP_DIV   = 4'd8,
        OP_MOD   = 4'd9,
        OP_RET   = 4'd10,
        OP_HALT  = 4'd11,
        OP_DUMP  = 4'd12
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_DIV_ZERO  = 3'd3,
        ST_BAD_INDEX = 3'd4,
        ST_UNKNOWN   = 3'd5
    } t_status;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_ram_wr;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

/* design/stack_machine_executor_core.sv */
// Sequence: none, push, scan, halt and faults found at acceptance go from acceptance to
// S_EMIT; load, print and ret pass through S_LOAD_WR, S_PRINT or S_RET; add, sub and mul
// take S_RD_A, S_EXEC and S_WB, div and mod wait in S_DIV between S_EXEC and S_WB, and a
// divide by zero goes from S_EXEC to S_EMIT. Dump gives one entry a cycle while the output is
// free. Items are taken only in S_IDLE, one at a time; the stack memory has a single read port.
// Reset: synchronous active low; clears pointers and handshake, sets the run flag; memory is not.
// ----------------------------------------------------------------------------
// Stack machine executor core
// Executes one instruction of a 32-bit signed operand-stack machine per item,
// keeping the operand stack in a synchronous memory and reporting each step.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_machine_executor_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Instruction channel.
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic        [smx_pkg::REQ_W-1:0]    i_req_type,
    input  wire logic signed [smx_pkg::DATA_W-1:0]   i_operand,
    input  wire logic signed [smx_pkg::DATA_W-1:0]   i_scan_value,
    // Result channel.
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic        [smx_pkg::NEXT_IP_W-1:0]     o_next_ip,
    output logic                                     o_data_valid,
    output logic signed [smx_pkg::DATA_W-1:0]        o_data_value,
    output logic                                     o_last,
    output logic        [smx_pkg::STATUS_W-1:0]      o_status,
    output logic                                     o_halted,
    output logic        [smx_pkg::DEPTH_OUT_W-1:0]   o_stack_depth
);

    // The sequencer walks each instruction through the memory: the accept cycle issues
    // the first read (or the push write), later states consume the registered read data,
    // and the write-back always lands before the next item can issue its own read, so
    // no forwarding path is needed.
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_WR,
        S_PRINT,
        S_RET,
        S_RD_A,
        S_EXEC,
        S_DIV,
        S_WB,
        S_EMIT,
        S_DUMP_OUT
    } t_state;

    t_state                          r_state;
    smx_pkg::t_op                    r_op;
    logic [smx_pkg::SP_W-1:0]        r_sp;
    logic [smx_pkg::IP_BITS-1:0]     r_ip;
    logic                            r_running;
    logic [smx_pkg::DATA_W-1:0]      r_b;
    logic [smx_pkg::DATA_W-1:0]      r_res;
    logic                            r_na;
    logic                            r_nb;
    logic [smx_pkg::ADDR_W-1:0]      r_cnt;
    smx_pkg::t_status                r_status;
    logic                            r_dvalid;
    logic [smx_pkg::DATA_W-1:0]      r_data;

    // Output register, which lets the next item start while a result waits.
    logic                            r_out_valid;
    logic [smx_pkg::NEXT_IP_W-1:0]   r_out_ip;
    logic                            r_out_dvalid;
    logic [smx_pkg::DATA_W-1:0]      r_out_data;
    logic                            r_out_last;
    smx_pkg::t_status                r_out_status;
    logic                            r_out_halted;
    logic [smx_pkg::DEPTH_OUT_W-1:0] r_out_depth;

    smx_pkg::t_ram_wr                w_wr;
    logic [smx_pkg::ADDR_W-1:0]      w_rd_addr;
    logic [smx_pkg::DATA_W-1:0]      w_rd_data;
    smx_pkg::t_div_req               w_div_req;
    smx_pkg::t_div_rsp               w_div_rsp;

    smx_pkg::t_op                    w_in_op;
    logic                            w_accept;
    logic                            w_out_free;
    logic                            w_out_load;
    logic                            w_full;
    logic                            w_bad_index;
    logic [smx_pkg::ADDR_W-1:0]      w_top_addr;
    logic [smx_pkg::ADDR_W-1:0]      w_second_addr;
    logic [smx_pkg::IP_BITS-1:0]     w_ip_adv;
    logic [smx_pkg::DATA_W-1:0]      w_prod;
    logic                            w_dump_last;
    logic [smx_pkg::DATA_W-1:0]      w_quo_signed;
    logic [smx_pkg::DATA_W-1:0]      w_rem_signed;

    function automatic logic [smx_pkg::DATA_W-1:0] umag(input logic [smx_pkg::DATA_W-1:0] v);
        umag = v[smx_pkg::DATA_W-1] ? (smx_pkg::DATA_W'(0) - v) : v;
    endfunction

    assign w_in_op       = smx_pkg::t_op'(i_req_type);
    assign o_in_ready    = (r_state == S_IDLE);
    assign w_accept      = i_in_valid && o_in_ready;
    assign w_out_free    = !r_out_valid || i_out_ready;
    // The output register takes a new result item in this cycle.
    assign w_out_load    = w_out_free && (r_state == S_EMIT || r_state == S_DUMP_OUT);
    assign w_full        = (r_sp == smx_pkg::SP_W'(smx_pkg::STACK_DEPTH));
    // Negative indexes and indexes at or above the depth do not name a live entry.
    assign w_bad_index   = i_operand[smx_pkg::DATA_W-1] ||
                           ($unsigned(i_operand) >= smx_pkg::DATA_W'(r_sp));
    assign w_top_addr    = smx_pkg::ADDR_W'(r_sp - smx_pkg::SP_W'(1));
    assign w_second_addr = smx_pkg::ADDR_W'(r_sp - smx_pkg::SP_W'(2));
    assign w_ip_adv      = r_ip + 1'b1;
    // In S_EXEC the read data carries the second operand from the top.
    assign w_prod        = w_rd_data * r_b;
    assign w_dump_last   = (r_cnt == w_top_addr);
    assign w_quo_signed  = (r_na != r_nb) ? (smx_pkg::DATA_W'(0) - w_div_rsp.quotient)
                                          : w_div_rsp.quotient;
    assign w_rem_signed  = r_na ? (smx_pkg::DATA_W'(0) - w_div_rsp.remainder)
                                : w_div_rsp.remainder;

    // Memory write port: push-type items write in their accept cycle, load copies the
    // read entry to the new top, and arithmetic writes its result over the lower operand.
    always_comb begin
        w_wr      = '0;
        w_rd_addr = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && r_running && !w_full &&
                    (w_in_op == smx_pkg::OP_PUSH || w_in_op == smx_pkg::OP_SCAN ||
                     w_in_op == smx_pkg::OP_HALT)) begin
                    w_wr.we   = 1'b1;
                    w_wr.addr = smx_pkg::ADDR_W'(r_sp);
                    w_wr.data = (w_in_op == smx_pkg::OP_SCAN) ? i_scan_value : i_operand;
                end
                if (w_in_op == smx_pkg::OP_LOAD) begin
                    w_rd_addr = i_operand[smx_pkg::ADDR_W-1:0];
                end else if (w_in_op == smx_pkg::OP_DUMP) begin
                    w_rd_addr = '0;
                end else begin
                    w_rd_addr = w_top_addr;
                end
            end
            S_LOAD_WR: begin
                w_wr.we   = 1'b1;
                w_wr.addr = smx_pkg::ADDR_W'(r_sp);
                w_wr.data = w_rd_data;
            end
            S_RD_A: begin
                w_rd_addr = w_second_addr;
            end
            S_WB: begin
                w_wr.we   = 1'b1;
                w_wr.addr = w_second_addr;
                w_wr.data = r_res;
            end
            S_DUMP_OUT: begin
                // Step to the next entry only when this one leaves; otherwise re-read it.
                w_rd_addr = w_out_free ? (r_cnt + 1'b1) : r_cnt;
            end
            default: begin
                w_rd_addr = r_cnt;
            end
        endcase
    end

    always_comb begin
        w_div_req          = '0;
        w_div_req.dividend = umag(w_rd_data);
        w_div_req.divisor  = umag(r_b);
        w_div_req.start    = (r_state == S_EXEC) && (r_b != '0) &&
                             (r_op == smx_pkg::OP_DIV || r_op == smx_pkg::OP_MOD);
    end

    smx_stack_ram u_stack_ram (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    smx_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_ip        <= '0;
            r_running   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op     <= w_in_op;
                        r_status <= smx_pkg::ST_OK;
                        r_dvalid <= 1'b0;
                        r_data   <= '0;
                        r_state  <= S_EMIT;
                        // A halted machine ignores the item and reports status ok.
                        if (r_running) begin
                            unique case (w_in_op)
                                smx_pkg::OP_NONE: begin
                                end
                                smx_pkg::OP_PUSH, smx_pkg::OP_SCAN, smx_pkg::OP_HALT: begin
                                    if (w_full) begin
                                        r_status <= smx_pkg::ST_OVERFLOW;
                                    end else begin
                                        r_sp <= r_sp + 1'b1;
                                        r_ip <= w_ip_adv;
                                        if (w_in_op == smx_pkg::OP_HALT) begin
                                            r_running <= 1'b0;
                                        end
                                    end
                                end
                                smx_pkg::OP_LOAD: begin
                                    if (w_full) begin
                                        r_status <= smx_pkg::ST_OVERFLOW;
                                    end else if (w_bad_index) begin
                                        r_status <= smx_pkg::ST_BAD_INDEX;
                                    end else begin
                                        r_state <= S_LOAD_WR;
                                    end
                                end
                                smx_pkg::OP_PRINT: begin
                                    if (r_sp == '0) begin
                                        r_status <= smx_pkg::ST_UNDERFLOW;
                                    end else begin
                                        r_state <= S_PRINT;
                                    end
                                end
                                smx_pkg::OP_RET: begin
                                    if (r_sp == '0) begin
                                        r_status <= smx_pkg::ST_UNDERFLOW;
                                    end else begin
                                        r_state <= S_RET;
                                    end
                                end
                                smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL,
                                smx_pkg::OP_DIV, smx_pkg::OP_MOD: begin
                                    if (r_sp < smx_pkg::SP_W'(2)) begin
                                        r_status <= smx_pkg::ST_UNDERFLOW;
                                    end else begin
                                        r_state <= S_RD_A;
                                    end
                                end
                                smx_pkg::OP_DUMP: begin
                                    // Dump always advances; an empty stack gives one
                                    // result without data.
                                    r_ip <= w_ip_adv;
                                    if (r_sp != '0) begin
                                        r_cnt   <= '0;
                                        r_state <= S_DUMP_OUT;
                                    end
                                end
                                default: begin
                                    r_running <= 1'b0;
                                    r_status  <= smx_pkg::ST_UNKNOWN;
                                end
                            endcase
                        end
                    end
                end
                S_LOAD_WR: begin
                    r_sp    <= r_sp + 1'b1;
                    r_ip    <= w_ip_adv;
                    r_state <= S_EMIT;
                end
                S_PRINT: begin
                    r_dvalid <= 1'b1;
                    r_data   <= w_rd_data;
                    r_ip     <= w_ip_adv;
                    r_state  <= S_EMIT;
                end
                S_RET: begin
                    r_sp    <= r_sp - 1'b1;
                    r_ip    <= w_rd_data[smx_pkg::IP_BITS-1:0];
                    r_state <= S_EMIT;
                end
                S_RD_A: begin
                    r_b     <= w_rd_data;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_na <= w_rd_data[smx_pkg::DATA_W-1];
                    r_nb <= r_b[smx_pkg::DATA_W-1];
                    priority if ((r_op == smx_pkg::OP_DIV || r_op == smx_pkg::OP_MOD) &&
                                 r_b == '0) begin
                        r_status <= smx_pkg::ST_DIV_ZERO;
                        r_state  <= S_EMIT;
                    end else if (r_op == smx_pkg::OP_ADD) begin
                        r_res   <= w_rd_data + r_b;
                        r_state <= S_WB;
                    end else if (r_op == smx_pkg::OP_SUB) begin
                        r_res   <= w_rd_data - r_b;
                        r_state <= S_WB;
                    end else if (r_op == smx_pkg::OP_MUL) begin
                        r_res   <= w_prod;
                        r_state <= S_WB;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // Quotient is negated on differing signs; remainder follows the dividend.
                    if (w_div_rsp.done) begin
                        r_res   <= (r_op == smx_pkg::OP_DIV) ? w_quo_signed : w_rem_signed;
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_sp    <= r_sp - 1'b1;
                    r_ip    <= w_ip_adv;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_ip     <= smx_pkg::NEXT_IP_W'(r_ip);
                        r_out_dvalid <= r_dvalid;
                        r_out_data   <= r_data;
                        r_out_last   <= 1'b1;
                        r_out_status <= r_status;
                        r_out_halted <= !r_running;
                        r_out_depth  <= smx_pkg::DEPTH_OUT_W'(r_sp);
                        r_state      <= S_IDLE;
                    end
                end
                S_DUMP_OUT: begin
                    // The read data always holds the entry at r_cnt here.
                    if (w_out_free) begin
                        r_out_ip     <= smx_pkg::NEXT_IP_W'(r_ip);
                        r_out_dvalid <= 1'b1;
                        r_out_data   <= w_rd_data;
                        r_out_last   <= w_dump_last;
                        r_out_status <= smx_pkg::ST_OK;
                        r_out_halted <= !r_running;
                        r_out_depth  <= smx_pkg::DEPTH_OUT_W'(r_sp);
                        if (w_dump_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_next_ip     = r_out_ip;
    assign o_data_valid  = r_out_dvalid;
    assign o_data_value  = r_out_data;
    assign o_last        = r_out_last;
    assign o_status      = r_out_status;
    assign o_halted      = r_out_halted;
    assign o_stack_depth = r_out_depth;

endmodule

`default_nettype wire

/* design/smx_stack_ram.sv */
// ----------------------------------------------------------------------------
// Operand stack memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_stack_ram (
    input  wire logic                           i_clk,
    input  wire smx_pkg::t_ram_wr               i_wr,
    input  wire logic [smx_pkg::ADDR_W-1:0]     i_rd_addr,
    output logic      [smx_pkg::DATA_W-1:0]     o_rd_data
);

    logic [smx_pkg::DATA_W-1:0] mem [smx_pkg::STACK_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

`default_nettype wire

/* design/smx_divider.sv */
// ----------------------------------------------------------------------------
// Unsigned iterative divider
// Restoring division, one quotient bit per cycle, done pulses for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire smx_pkg::t_div_req i_req,
    output smx_pkg::t_div_rsp      o_rsp
);

    logic                            r_busy;
    logic                            r_done;
    logic [smx_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [smx_pkg::DATA_W-1:0]      r_rem;
    logic [smx_pkg::DATA_W-1:0]      r_quo;
    logic [smx_pkg::DATA_W-1:0]      r_dvs;
    logic [smx_pkg::DATA_W:0]        w_shift;
    logic [smx_pkg::DATA_W:0]        w_diff;

    assign w_shift = {r_rem, r_quo[smx_pkg::DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                // A clear borrow bit means the divisor fits into the partial remainder.
                if (!w_diff[smx_pkg::DATA_W]) begin
                    r_rem <= w_diff[smx_pkg::DATA_W-1:0];
                    r_quo <= {r_quo[smx_pkg::DATA_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[smx_pkg::DATA_W-1:0];
                    r_quo <= {r_quo[smx_pkg::DATA_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == smx_pkg::DIV_CNT_W'(smx_pkg::DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

/* design/stack_machine_executor_core_checker.sv */
// ----------------------------------------------------------------------------
// Stack machine executor port checker
// Watches the executor's ports and flags results that break its contract.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stack_machine_executor_core_macros.svh"

module stack_machine_executor_core_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_in_valid,
    input wire logic                                o_in_ready,
    input wire logic                                o_out_valid,
    input wire logic                                i_out_ready,
    input wire logic        [smx_pkg::NEXT_IP_W-1:0]   o_next_ip,
    input wire logic                                o_data_valid,
    input wire logic signed [smx_pkg::DATA_W-1:0]   o_data_value,
    input wire logic                                o_last,
    input wire logic        [smx_pkg::STATUS_W-1:0]    o_status,
    input wire logic                                o_halted,
    input wire logic        [smx_pkg::DEPTH_OUT_W-1:0] o_stack_depth
);

    logic w_out_wait;
    logic w_out_fault;
    logic w_depth_ok;
    logic [smx_pkg::NEXT_IP_W + smx_pkg::DATA_W + smx_pkg::STATUS_W +
           smx_pkg::DEPTH_OUT_W + 2:0] w_payload;

    assign w_out_wait  = o_out_valid && !i_out_ready;
    assign w_out_fault = o_out_valid && (o_status != smx_pkg::ST_OK);
    assign w_depth_ok  = (o_stack_depth <= smx_pkg::DEPTH_OUT_W'(smx_pkg::STACK_DEPTH));
    assign w_payload   = {o_next_ip, o_data_valid, o_data_value, o_last, o_status,
                          o_halted, o_stack_depth};

    // A waiting result keeps its contents until it is taken.
    `SMX_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_out_wait, o_out_valid && $stable(w_payload))

    // A fault ends the instruction with a single result and no data.
    `SMX_ASSERT_IMP(a_fault_single, i_clk, i_rst_n, w_out_fault, o_last && !o_data_valid)

    // Data is zero whenever it is not marked as carrying a value.
    `SMX_ASSERT_IMP(a_data_zero, i_clk, i_rst_n, o_out_valid && !o_data_valid, o_data_value == '0)

    // The reported depth never exceeds the stack size.
    `SMX_ASSERT_IMP(a_depth_range, i_clk, i_rst_n, o_out_valid, w_depth_ok)

    // Items are taken one at a time: an accept is never followed by another at once.
    `SMX_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind stack_machine_executor_core stack_machine_executor_core_checker u_checker (.*);

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stack machine executor core testbench
// Sends instruction items to the executor and checks every result item against
// a predictor of the machine: stack, stack pointer, fetch address and halt
// flag. Directed programs cover arithmetic edge cases, loads, returns, the
// stack limits and halting, and random programs follow. Both channels idle and
// stall in several phases.
// ----------------------------------------------------------------------------

module tb;

    import smx_pkg::*;

    // Opcodes above dump are not defined and stop the machine.
    localparam logic [REQ_W-1:0] FIRST_UNKNOWN_OP = 4'd13;
    localparam logic [REQ_W-1:0] LAST_OP_CODE     = 4'd15;

    // Run limit in ns, far beyond the slowest correct run.
    localparam int WATCHDOG_NS = 5_000_000;

    // Idle percentages for the phases of the run.
    localparam int IDLE_HEAVY = 56;
    localparam int IDLE_BOTH  = 37;

    localparam int RANDOM_ITEMS_PER_PHASE = 46;
    localparam int MAX_PRINTED_ERRORS     = 100;

    // One predicted result item, field by field.
    typedef struct {
        logic [NEXT_IP_W-1:0]   next_ip;
        logic                   data_valid;
        logic [DATA_W-1:0]      data_value;
        logic                   last;
        t_status                status;
        logic                   halted;
        logic [DEPTH_OUT_W-1:0] depth;
    } t_step_result;

    // ------------------------------------------------------------------------
    // Block inputs start at known values; reset is held from time zero.
    // ------------------------------------------------------------------------
    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic [REQ_W-1:0]         i_req_type   = '0;
    logic signed [DATA_W-1:0] i_operand    = '0;
    logic signed [DATA_W-1:0] i_scan_value = '0;
    logic                     i_out_ready  = 1'b0;

    logic                     o_in_ready;
    logic                     o_out_valid;
    logic [NEXT_IP_W-1:0]     o_next_ip;
    logic                     o_data_valid;
    logic signed [DATA_W-1:0] o_data_value;
    logic                     o_last;
    logic [STATUS_W-1:0]      o_status;
    logic                     o_halted;
    logic [DEPTH_OUT_W-1:0]   o_stack_depth;

    stack_machine_executor_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_operand     (i_operand),
        .i_scan_value  (i_scan_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_next_ip     (o_next_ip),
        .o_data_valid  (o_data_valid),
        .o_data_value  (o_data_value),
        .o_last        (o_last),
        .o_status      (o_status),
        .o_halted      (o_halted),
        .o_stack_depth (o_stack_depth)
    );

    // ------------------------------------------------------------------------
    // Predictor state: the machine as the block should see it after every
    // accepted item.
    // ------------------------------------------------------------------------
    logic [DATA_W-1:0]  model_stack [STACK_DEPTH];
    int unsigned        model_sp      = 0;
    logic [IP_BITS-1:0] model_ip      = '0;
    logic               model_running = 1'b1;

    // Result items predicted but not yet seen on the output channel.
    t_step_result pending_results [$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    int n_sent         = 0;
    int n_checked      = 0;
    int n_errors       = 0;
    int n_faults       = 0;
    int n_dump_entries = 0;

    // 10 ns clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // A hard limit on the run, in case the block stops answering.
    initial begin
        #(WATCHDOG_NS);
        $display("Timeout: %0d result items still pending.", pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_PRINTED_ERRORS)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s: got %h, expected %h",
                                      n_checked, name, got, want));
    endtask

    // Queues one predicted result item built from the machine state as it
    // stands now, so callers update the state first.
    task automatic push_result(input logic dv, input logic [DATA_W-1:0] value,
                               input logic fin, input t_status st);
        t_step_result res;
        res.next_ip    = NEXT_IP_W'(model_ip);
        res.data_valid = dv;
        res.data_value = dv ? value : '0;
        res.last       = fin;
        res.status     = st;
        res.halted     = !model_running;
        res.depth      = DEPTH_OUT_W'(model_sp);
        pending_results.push_back(res);
        if (st != ST_OK)
            n_faults++;
    endtask

    // ------------------------------------------------------------------------
    // Predictor: executes one instruction on the model state and queues the
    // result items it causes. A fault leaves the stack, its pointer and the fetch
    // address untouched and yields a single item carrying the status.
    // ------------------------------------------------------------------------
    task automatic execute_instr(input logic [REQ_W-1:0] op, input logic [DATA_W-1:0] imm,
                                 input logic [DATA_W-1:0] scan);
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  b;
        logic [DATA_W-1:0]  r;
        logic [DATA_W-1:0]  ma;
        logic [DATA_W-1:0]  mb;
        logic [IP_BITS-1:0] adv;
        adv = model_ip + 1'b1;

        // A stopped machine ignores the item but still answers it.
        if (!model_running) begin
            push_result(1'b0, '0, 1'b1, ST_OK);
            return;
        end

        case (op)
            OP_NONE: begin
                push_result(1'b0, '0, 1'b1, ST_OK);
            end
            OP_PUSH, OP_SCAN, OP_HALT: begin
                // Halt pushes its operand too, so a full stack makes it an
                // overflow and the machine keeps running.
                if (model_sp >= STACK_DEPTH) begin
                    push_result(1'b0, '0, 1'b1, ST_OVERFLOW);
                end else begin
                    model_stack[model_sp] = (op == OP_SCAN) ? scan : imm;
                    model_sp++;
                    model_ip = adv;
                    if (op == OP_HALT)
                        model_running = 1'b0;
                    push_result(1'b0, '0, 1'b1, ST_OK);
                end
            end
            OP_LOAD: begin
                // Overflow takes priority over a bad index.
                if (model_sp >= STACK_DEPTH) begin
                    push_result(1'b0, '0, 1'b1, ST_OVERFLOW);
                end else if (imm[DATA_W-1] || imm >= model_sp) begin
                    push_result(1'b0, '0, 1'b1, ST_BAD_INDEX);
                end else begin
                    model_stack[model_sp] = model_stack[imm];
                    model_sp++;
                    model_ip = adv;
                    push_result(1'b0, '0, 1'b1, ST_OK);
                end
            end
            OP_PRINT: begin
                if (model_sp < 1) begin
                    push_result(1'b0, '0, 1'b1, ST_UNDERFLOW);
                end else begin
                    model_ip = adv;
                    push_result(1'b1, model_stack[model_sp-1], 1'b1, ST_OK);
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                if (model_sp < 2) begin
                    push_result(1'b0, '0, 1'b1, ST_UNDERFLOW);
                end else begin
                    a = model_stack[model_sp-2];
                    b = model_stack[model_sp-1];
                    if ((op == OP_DIV || op == OP_MOD) && b == '0) begin
                        push_result(1'b0, '0, 1'b1, ST_DIV_ZERO);
                    end else begin
                        // Division works on magnitudes: the quotient is
                        // negated when the signs differ, the remainder takes
                        // the sign of the dividend.
                        ma = a[DATA_W-1] ? ('0 - a) : a;
                        mb = b[DATA_W-1] ? ('0 - b) : b;
                        case (op)
                            OP_ADD: r = a + b;
                            OP_SUB: r = a - b;
                            OP_MUL: r = a * b;
                            OP_DIV: begin
                                r = ma / mb;
                                if (a[DATA_W-1] != b[DATA_W-1])
                                    r = '0 - r;
                            end
                            default: begin
                                r = ma % mb;
                                if (a[DATA_W-1])
                                    r = '0 - r;
                            end
                        endcase
                        model_stack[model_sp-2] = r;
                        model_sp--;
                        model_ip = adv;
                        push_result(1'b0, '0, 1'b1, ST_OK);
                    end
                end
            end
            OP_RET: begin
                if (model_sp < 1) begin
                    push_result(1'b0, '0, 1'b1, ST_UNDERFLOW);
                end else begin
                    model_ip = model_stack[model_sp-1][IP_BITS-1:0];
                    model_sp--;
                    push_result(1'b0, '0, 1'b1, ST_OK);
                end
            end
            OP_DUMP: begin
                // Dump always advances, even with nothing to show.
                model_ip = adv;
                if (model_sp == 0) begin
                    push_result(1'b0, '0, 1'b1, ST_OK);
                end else begin
                    for (int k = 0; k < model_sp; k++) begin
                        push_result(1'b1, model_stack[k], (k + 1) == model_sp, ST_OK);
                        n_dump_entries++;
                    end
                end
            end
            default: begin
                model_running = 1'b0;
                push_result(1'b0, '0, 1'b1, ST_UNKNOWN);
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Sender: optional idle cycles, then one item held until accepted. Valid
    // is left high afterwards so back-to-back items need a single assignment
    // per clock edge; the next call or the end of the stimulus lowers it.
    // ------------------------------------------------------------------------
    task automatic send_instr(input logic [REQ_W-1:0] op, input logic [DATA_W-1:0] imm,
                              input logic [DATA_W-1:0] scan);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= op;
        i_operand    <= imm;
        i_scan_value <= scan;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        execute_instr(op, imm, scan);
        n_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Result checker. Outputs are read right after the edge, before the
    // block's own updates land, so they are the values the edge sampled. The
    // same block draws the receiver's stall for the next cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_step_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result item with nothing pending, next_ip %h",
                                          o_next_ip));
            end else begin
                want = pending_results.pop_front();
                check_field("next_ip", o_next_ip, want.next_ip);
                check_field("data_valid", o_data_valid, want.data_valid);
                check_field("data_value", o_data_value, want.data_value);
                check_field("last", o_last, want.last);
                check_field("status", o_status, want.status);
                check_field("halted", o_halted, want.halted);
                check_field("stack_depth", o_stack_depth, want.depth);
                n_checked++;
            end
        end
        i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // An operand value that leans on the corners of the 32-bit range.
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h8000_0000;
            5:       return $urandom_range(32) - 16;
            default: return $urandom();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Random instruction generator. Most items form a sensible program for
    // the current stack depth so the arithmetic, loads and dumps see real
    // data; a share is noise with any defined opcode and raw operands. Halt
    // is only drawn on a full stack, where it overflows and the run goes on.
    // ------------------------------------------------------------------------
    task automatic pick_random_instr(output logic [REQ_W-1:0] op,
                                     output logic [DATA_W-1:0] imm,
                                     output logic [DATA_W-1:0] scan);
        int unsigned roll;
        bit          is_noise;
        imm      = pick_value();
        scan     = pick_value();
        roll     = $urandom_range(99);
        is_noise = (roll < 8);
        if (is_noise) begin
            op  = REQ_W'($urandom_range(OP_NONE, OP_DUMP));
            imm = $urandom();
            if (op == OP_HALT && model_sp < STACK_DEPTH)
                op = OP_NONE;
        end else if (model_sp < 2) begin
            roll = $urandom_range(99);
            if (roll < 55)      op = OP_PUSH;
            else if (roll < 80) op = OP_SCAN;
            else if (roll < 90) op = OP_LOAD;
            else                op = OP_PRINT;
        end else if (model_sp >= STACK_DEPTH) begin
            // A full stack: some overflow attempts, mostly ways back down.
            roll = $urandom_range(99);
            if (roll < 25) begin
                case ($urandom_range(3))
                    0:       op = OP_PUSH;
                    1:       op = OP_SCAN;
                    2:       op = OP_LOAD;
                    default: op = OP_HALT;
                endcase
            end else if (roll < 85) begin
                op = REQ_W'($urandom_range(OP_ADD, OP_MOD));
            end else if (roll < 95) begin
                op = OP_DUMP;
            end else begin
                op = OP_RET;
            end
        end else begin
            roll = $urandom_range(99);
            if (roll < 20)      op = OP_PUSH;
            else if (roll < 28) op = OP_SCAN;
            else if (roll < 38) op = OP_LOAD;
            else if (roll < 44) op = OP_PRINT;
            else if (roll < 52) op = OP_ADD;
            else if (roll < 60) op = OP_SUB;
            else if (roll < 68) op = OP_MUL;
            else if (roll < 76) op = OP_DIV;
            else if (roll < 84) op = OP_MOD;
            else if (roll < 89) op = OP_RET;
            else if (roll < 96) op = OP_DUMP;
            else                op = OP_NONE;
        end
        // Well-formed loads mostly use an index that is in range.
        if (op == OP_LOAD && !is_noise && model_sp > 0 && $urandom_range(99) < 85)
            imm = $urandom_range(model_sp - 1);
    endtask

    // ------------------------------------------------------------------------
    // Directed: add and multiply wrap, most negative over minus one, signs of
    // quotient and remainder, divide by zero, subtraction.
    // ------------------------------------------------------------------------
    task automatic test_arithmetic();
        send_instr(OP_NONE, $urandom(), $urandom());
        send_instr(OP_PUSH, 32'h7FFF_FFFF, $urandom());
        send_instr(OP_PUSH, 32'h0000_0001, $urandom());
        send_instr(OP_ADD, $urandom(), $urandom());          // wraps to most negative
        send_instr(OP_SCAN, $urandom(), 32'hFFFF_FFFF);
        send_instr(OP_MUL, $urandom(), $urandom());          // most negative again
        send_instr(OP_SCAN, $urandom(), 32'hFFFF_FFFF);
        send_instr(OP_DIV, $urandom(), $urandom());          // stays most negative
        send_instr(OP_PUSH, 32'hFFFF_FFFF, $urandom());
        send_instr(OP_MOD, $urandom(), $urandom());          // zero
        send_instr(OP_PUSH, 32'hFFFF_FFF9, $urandom());
        send_instr(OP_SUB, $urandom(), $urandom());          // 0 - (-7) = 7
        send_instr(OP_PUSH, 32'hFFFF_FFFE, $urandom());
        send_instr(OP_DIV, $urandom(), $urandom());          // 7 / -2 = -3
        send_instr(OP_PUSH, 32'h0000_0002, $urandom());
        send_instr(OP_MOD, $urandom(), $urandom());          // -3 % 2 = -1
        send_instr(OP_PUSH, 32'h0000_0000, $urandom());
        send_instr(OP_DIV, $urandom(), $urandom());          // divide by zero
        send_instr(OP_MOD, $urandom(), $urandom());          // divide by zero
        send_instr(OP_SUB, $urandom(), $urandom());
    endtask

    // ------------------------------------------------------------------------
    // Directed: print, loads in and out of range, a return to the top of the
    // address space followed by a wrapping advance, and a dump.
    // ------------------------------------------------------------------------
    task automatic test_load_print_return();
        send_instr(OP_PRINT, $urandom(), $urandom());
        send_instr(OP_LOAD, 32'h0000_0000, $urandom());
        send_instr(OP_LOAD, 32'hFFFF_FFFF, $urandom());      // negative index
        send_instr(OP_LOAD, model_sp, $urandom());           // index equal to depth
        send_instr(OP_LOAD, 32'h8000_0000, $urandom());
        send_instr(OP_PUSH, 32'h0001_FFFF, $urandom());
        send_instr(OP_RET, $urandom(), $urandom());          // fetch address truncated
        send_instr(OP_PUSH, 32'h0000_0005, $urandom());      // address wraps to zero
        send_instr(OP_DUMP, $urandom(), $urandom());
    endtask

    // ------------------------------------------------------------------------
    // Directed: underflow on an empty and a one-entry stack, an empty dump,
    // then a full stack with every overflow case and a full dump.
    // ------------------------------------------------------------------------
    task automatic test_stack_limits();
        while (model_sp > 0)
            send_instr(OP_RET, $urandom(), $urandom());
        send_instr(OP_PRINT, $urandom(), $urandom());
        send_instr(OP_RET, $urandom(), $urandom());
        send_instr(OP_ADD, $urandom(), $urandom());
        send_instr(OP_DUMP, $urandom(), $urandom());         // empty stack still advances
        send_instr(OP_PUSH, 32'h0000_0003, $urandom());
        send_instr(OP_SUB, $urandom(), $urandom());          // only one entry
        while (model_sp < STACK_DEPTH)
            send_instr($urandom_range(1) ? OP_PUSH : OP_SCAN, pick_value(), pick_value());
        send_instr(OP_PUSH, $urandom(), $urandom());
        send_instr(OP_SCAN, $urandom(), $urandom());
        send_instr(OP_LOAD, 32'h0000_0000, $urandom());
        send_instr(OP_HALT, $urandom(), $urandom());         // overflow, keeps running
        send_instr(OP_DUMP, $urandom(), $urandom());
        send_instr(OP_PRINT, $urandom(), $urandom());
        // Come back down with operations that cannot fault.
        while (model_sp > 6)
            send_instr(REQ_W'($urandom_range(OP_ADD, OP_MUL)), $urandom(), $urandom());
    endtask

    task automatic test_random_program(input int count, input int tx_pct, input int rx_pct);
        logic [REQ_W-1:0]  op;
        logic [DATA_W-1:0] imm;
        logic [DATA_W-1:0] scan;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) begin
            pick_random_instr(op, imm, scan);
            send_instr(op, imm, scan);
        end
    endtask

    // ------------------------------------------------------------------------
    // The machine can only stop once per run, so this comes last: either a
    // halt or an unknown opcode, chosen at random, and then a few items that
    // a stopped machine must ignore, every unknown code among them.
    // ------------------------------------------------------------------------
    task automatic test_halt_and_ignore();
        if ($urandom_range(1)) begin
            while (model_sp >= STACK_DEPTH)
                send_instr(OP_ADD, $urandom(), $urandom());
            send_instr(OP_HALT, pick_value(), $urandom());
        end else begin
            send_instr(REQ_W'($urandom_range(FIRST_UNKNOWN_OP, LAST_OP_CODE)),
                       $urandom(), $urandom());
        end
        send_instr(OP_PUSH, $urandom(), $urandom());
        send_instr(OP_DUMP, $urandom(), $urandom());
        send_instr(OP_HALT, $urandom(), $urandom());
        for (int code = FIRST_UNKNOWN_OP; code <= LAST_OP_CODE; code++)
            send_instr(REQ_W'(code), $urandom(), $urandom());
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: one reset, the directed programs in different idle
    // phases, the random programs through all four phases, the stop, and a
    // drain with a few spare cycles to catch stray result items.
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        test_arithmetic();

        tx_idle_pct  = IDLE_HEAVY;
        rx_stall_pct = 0;
        test_load_print_return();

        tx_idle_pct  = 0;
        rx_stall_pct = IDLE_HEAVY;
        test_stack_limits();

        test_random_program(RANDOM_ITEMS_PER_PHASE, 0, 0);
        test_random_program(RANDOM_ITEMS_PER_PHASE, IDLE_HEAVY, 0);
        test_random_program(RANDOM_ITEMS_PER_PHASE, 0, IDLE_HEAVY);
        test_random_program(RANDOM_ITEMS_PER_PHASE, IDLE_BOTH, IDLE_BOTH);

        test_halt_and_ignore();
        i_in_valid <= 1'b0;

        // The watchdog covers a block that never delivers the rest.
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Run covered %0d instructions, %0d result items, %0d dump entries, %0d faults.",
                 n_sent, n_checked, n_dump_entries, n_faults);
        $display("Idle phases: none, sender %0d%%, receiver %0d%%, both %0d%%.",
                 IDLE_HEAVY, IDLE_HEAVY, IDLE_BOTH);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d result items never arrived.",
                     n_errors, pending_results.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
